[design/srq_pkg.sv]
package srq_pkg;

  localparam int unsigned DepthDefault  = 16;
  localparam int unsigned IdBitsDefault = 8;
  localparam int unsigned KeyBitsDefault = 32;

  typedef enum logic [1:0] {
    ACT_APPEND = 2'd0,
    ACT_INSERT = 2'd1,
    ACT_REMOVE = 2'd2
  } srq_action_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_INVALID   = 3'd1,
    ST_DUPLICATE = 3'd2,
    ST_EMPTY     = 3'd3,
    ST_FULL      = 3'd4
  } srq_status_e;

  // control broadcast from the top level to every cell
  typedef struct packed {
    logic ordered;
    logic insert;
    logic remove;
  } srq_ctrl_t;

endpackage

[design/srq_req_if.sv]
interface srq_req_if #(
  parameter int unsigned ID_BITS  = srq_pkg::IdBitsDefault,
  parameter int unsigned KEY_BITS = srq_pkg::KeyBitsDefault
);
  logic                       valid;
  logic                       ready;
  logic [1:0]                 action;
  logic [ID_BITS-1:0]         elem_id;
  logic signed [KEY_BITS-1:0] sort_key;

  modport source (output valid, action, elem_id, sort_key, input ready);
  modport sink   (input valid, action, elem_id, sort_key, output ready);
endinterface

[design/srq_rsp_if.sv]
interface srq_rsp_if #(
  parameter int unsigned DEPTH    = srq_pkg::DepthDefault,
  parameter int unsigned ID_BITS  = srq_pkg::IdBitsDefault,
  parameter int unsigned KEY_BITS = srq_pkg::KeyBitsDefault
);
  localparam int unsigned LenBits = $clog2(DEPTH + 1);

  logic                       valid;
  logic                       ready;
  logic [2:0]                 status;
  logic [ID_BITS-1:0]         popped_id;
  logic signed [KEY_BITS-1:0] popped_key;
  logic [LenBits-1:0]         queue_length;

  modport source (output valid, status, popped_id, popped_key, queue_length, input ready);
  modport sink   (input valid, status, popped_id, popped_key, queue_length, output ready);
endinterface

[design/sorted_ready_queue_top.sv]
// Response valid rises in the cycle after request acceptance.
// Throughput: one request per cycle while responses are taken; each cell compares and shifts in parallel,
// the insertion point and duplicate flag ripple along the cell row.
// Request ready drops only while a response is held and not taken.
// Reset (rst_ni low, asynchronous) empties the queue and drops response valid.
module sorted_ready_queue_top #(
  parameter int unsigned DEPTH    = srq_pkg::DepthDefault,
  parameter int unsigned ID_BITS  = srq_pkg::IdBitsDefault,
  parameter int unsigned KEY_BITS = srq_pkg::KeyBitsDefault
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  srq_req_if.sink   req_i,
  srq_rsp_if.source rsp_o
);
  import srq_pkg::*;

  localparam int unsigned LenBits = $clog2(DEPTH + 1);

  srq_ctrl_t                  ctrl;
  logic                       accept;
  logic [LenBits-1:0]         cnt_q, cnt_d;
  logic                       rsp_valid_q;
  srq_status_e                status_d, status_q;
  logic [ID_BITS-1:0]         pop_id_d, pop_id_q;
  logic signed [KEY_BITS-1:0] pop_key_d, pop_key_q;
  logic [LenBits-1:0]         len_q;

  logic                       cell_valid [DEPTH];
  logic [ID_BITS-1:0]         cell_id    [DEPTH];
  logic signed [KEY_BITS-1:0] cell_key   [DEPTH];
  logic [DEPTH:0]             take_chain;
  logic [DEPTH:0]             dup_chain;

  assign take_chain[0] = 1'b0;
  assign dup_chain[0]  = 1'b0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                       lv, rv;
    logic [ID_BITS-1:0]         lid, rid;
    logic signed [KEY_BITS-1:0] lkey, rkey;

    if (i == 0) begin : g_head
      assign lv   = 1'b0;
      assign lid  = '0;
      assign lkey = '0;
    end else begin : g_mid
      assign lv   = cell_valid[i-1];
      assign lid  = cell_id[i-1];
      assign lkey = cell_key[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign rv   = 1'b0;
      assign rid  = '0;
      assign rkey = '0;
    end else begin : g_body
      assign rv   = cell_valid[i+1];
      assign rid  = cell_id[i+1];
      assign rkey = cell_key[i+1];
    end

    srq_cell #(
      .ID_BITS (ID_BITS),
      .KEY_BITS(KEY_BITS)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .new_id_i     (req_i.elem_id),
      .new_key_i    (req_i.sort_key),
      .left_valid_i (lv),
      .left_id_i    (lid),
      .left_key_i   (lkey),
      .right_valid_i(rv),
      .right_id_i   (rid),
      .right_key_i  (rkey),
      .take_i       (take_chain[i]),
      .dup_i        (dup_chain[i]),
      .take_o       (take_chain[i+1]),
      .dup_o        (dup_chain[i+1]),
      .valid_o      (cell_valid[i]),
      .id_o         (cell_id[i]),
      .key_o        (cell_key[i])
    );
  end

  assign req_i.ready = ~rsp_valid_q | rsp_o.ready;
  assign accept      = req_i.valid & req_i.ready;

  always_comb begin
    ctrl         = '0;
    status_d     = ST_OK;
    pop_id_d     = '0;
    pop_key_d    = '0;
    cnt_d        = cnt_q;
    ctrl.ordered = (req_i.action == ACT_INSERT);
    unique case (req_i.action)
      ACT_APPEND, ACT_INSERT: begin
        if (req_i.elem_id == '0) begin
          status_d = ST_INVALID;
        end else if (dup_chain[DEPTH]) begin
          status_d = ST_DUPLICATE;
        end else if (cnt_q == LenBits'(DEPTH)) begin
          status_d = ST_FULL;
        end else begin
          ctrl.insert = accept;
          cnt_d       = cnt_q + LenBits'(1);
        end
      end
      ACT_REMOVE: begin
        if (cnt_q == '0) begin
          status_d = ST_EMPTY;
        end else begin
          ctrl.remove = accept;
          pop_id_d    = cell_id[0];
          pop_key_d   = cell_key[0];
          cnt_d       = cnt_q - LenBits'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        cnt_q <= cnt_d;
      end
      if (accept) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q  <= status_d;
      pop_id_q  <= pop_id_d;
      pop_key_q <= pop_key_d;
      len_q     <= cnt_d;
    end
  end

  assign rsp_o.valid        = rsp_valid_q;
  assign rsp_o.status       = status_q;
  assign rsp_o.popped_id    = pop_id_q;
  assign rsp_o.popped_key   = pop_key_q;
  assign rsp_o.queue_length = len_q;

endmodule

[design/srq_cell.sv]
module srq_cell #(
  parameter int unsigned ID_BITS  = srq_pkg::IdBitsDefault,
  parameter int unsigned KEY_BITS = srq_pkg::KeyBitsDefault
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  srq_pkg::srq_ctrl_t         ctrl_i,
  input  logic [ID_BITS-1:0]         new_id_i,
  input  logic signed [KEY_BITS-1:0] new_key_i,
  input  logic                       left_valid_i,
  input  logic [ID_BITS-1:0]         left_id_i,
  input  logic signed [KEY_BITS-1:0] left_key_i,
  input  logic                       right_valid_i,
  input  logic [ID_BITS-1:0]         right_id_i,
  input  logic signed [KEY_BITS-1:0] right_key_i,
  input  logic                       take_i,
  input  logic                       dup_i,
  output logic                       take_o,
  output logic                       dup_o,
  output logic                       valid_o,
  output logic [ID_BITS-1:0]         id_o,
  output logic signed [KEY_BITS-1:0] key_o
);
  import srq_pkg::*;

  logic                       valid_q, valid_d;
  logic [ID_BITS-1:0]         id_q, id_d;
  logic signed [KEY_BITS-1:0] key_q, key_d;
  logic                       here;

  // insertion point: first empty cell, or for an ordered insert the first cell with a strictly greater key
  assign here   = ~valid_q | (ctrl_i.ordered & (new_key_i < key_q));
  assign take_o = take_i | here;
  assign dup_o  = dup_i | (valid_q & (id_q == new_id_i));

  always_comb begin
    valid_d = valid_q;
    id_d    = id_q;
    key_d   = key_q;
    if (ctrl_i.insert) begin
      if (take_i) begin
        valid_d = left_valid_i;
        id_d    = left_id_i;
        key_d   = left_key_i;
      end else if (here) begin
        valid_d = 1'b1;
        id_d    = new_id_i;
        key_d   = new_key_i;
      end
    end else if (ctrl_i.remove) begin
      valid_d = right_valid_i;
      id_d    = right_id_i;
      key_d   = right_key_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    id_q  <= id_d;
    key_q <= key_d;
  end

  assign valid_o = valid_q;
  assign id_o    = id_q;
  assign key_o   = key_q;

endmodule

[design/srq_checker.sv]
module srq_checker #(
  parameter int unsigned DEPTH    = srq_pkg::DepthDefault,
  parameter int unsigned ID_BITS  = srq_pkg::IdBitsDefault,
  parameter int unsigned KEY_BITS = srq_pkg::KeyBitsDefault
) (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         rsp_valid_i,
  input logic                         rsp_ready_i,
  input logic [2:0]                   rsp_status_i,
  input logic [ID_BITS-1:0]           rsp_popped_id_i,
  input logic [$clog2(DEPTH+1)-1:0]   rsp_queue_length_i
);
  import srq_pkg::*;

  localparam int unsigned LenBits = $clog2(DEPTH + 1);

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_status_i)
      && $stable(rsp_popped_id_i) && $stable(rsp_queue_length_i))
    else $error("response changed while stalled");

  a_full_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_status_i == ST_FULL |-> rsp_queue_length_i == LenBits'(DEPTH))
    else $error("full status with queue not full");

  a_empty_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_status_i == ST_EMPTY
      |-> rsp_queue_length_i == '0 && rsp_popped_id_i == '0)
    else $error("empty status with entries or popped id");

  a_pop_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_popped_id_i != '0
      |-> rsp_status_i == ST_OK && rsp_queue_length_i != LenBits'(DEPTH))
    else $error("popped id on failed or impossible request");

endmodule

bind sorted_ready_queue_top srq_checker #(
  .DEPTH   (DEPTH),
  .ID_BITS (ID_BITS),
  .KEY_BITS(KEY_BITS)
) u_srq_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .rsp_valid_i       (rsp_o.valid),
  .rsp_ready_i       (rsp_o.ready),
  .rsp_status_i      (rsp_o.status),
  .rsp_popped_id_i   (rsp_o.popped_id),
  .rsp_queue_length_i(rsp_o.queue_length)
);

[dv/sorted_ready_queue_top_tb.sv]
module sorted_ready_queue_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import srq_pkg::*;

  localparam int unsigned Depth   = DepthDefault;
  localparam int unsigned IdBits  = IdBitsDefault;
  localparam int unsigned KeyBits = KeyBitsDefault;
  localparam int unsigned LenBits = $clog2(Depth + 1);

  localparam logic [1:0] ActUnused = 2'd3;
  localparam logic signed [KeyBits-1:0] KeyMin = {1'b1, {(KeyBits-1){1'b0}}};
  localparam logic signed [KeyBits-1:0] KeyMax = {1'b0, {(KeyBits-1){1'b1}}};
  localparam int unsigned CycleLimit = 200_000;

  typedef struct packed {
    srq_status_e               status;
    logic [IdBits-1:0]         popped_id;
    logic signed [KeyBits-1:0] popped_key;
    logic [LenBits-1:0]        queue_length;
  } queue_rsp_t;

  logic clk_i;
  logic rst_ni;

  srq_req_if #(.ID_BITS(IdBits), .KEY_BITS(KeyBits)) req_if ();
  srq_rsp_if #(.DEPTH(Depth), .ID_BITS(IdBits), .KEY_BITS(KeyBits)) rsp_if ();

  sorted_ready_queue_top #(
    .DEPTH   (Depth),
    .ID_BITS (IdBits),
    .KEY_BITS(KeyBits)
  ) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  // predicted queue contents, head first
  logic [IdBits-1:0]         held_ids[$];
  logic signed [KeyBits-1:0] held_keys[$];
  queue_rsp_t                expected_rsps[$];

  int unsigned error_count   = 0;
  int unsigned cycle_count   = 0;
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct     = 0;

  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CycleLimit) begin
      $display("sorted_ready_queue_top regression: fail");
      $finish;
    end
  end

  function automatic queue_rsp_t queue_apply(input logic [1:0] act,
                                             input logic [IdBits-1:0] id,
                                             input logic signed [KeyBits-1:0] key);
    queue_rsp_t rsp;
    int unsigned pos;
    bit held;
    rsp = '0;
    rsp.status = ST_OK;
    held = 1'b0;
    case (act)
      ACT_APPEND, ACT_INSERT: begin
        foreach (held_ids[i]) begin
          if (held_ids[i] == id) held = 1'b1;
        end
        if (id == '0) begin
          rsp.status = ST_INVALID;
        end else if (held) begin
          rsp.status = ST_DUPLICATE;
        end else if (held_ids.size() >= Depth) begin
          rsp.status = ST_FULL;
        end else begin
          pos = held_ids.size();
          if (act == ACT_INSERT) begin
            // first entry with a strictly greater key
            for (int unsigned i = 0; i < held_keys.size(); i++) begin
              if (key < held_keys[i]) begin
                pos = i;
                break;
              end
            end
          end
          held_ids.insert(pos, id);
          held_keys.insert(pos, key);
        end
      end
      ACT_REMOVE: begin
        if (held_ids.size() == 0) begin
          rsp.status = ST_EMPTY;
        end else begin
          rsp.popped_id  = held_ids.pop_front();
          rsp.popped_key = held_keys.pop_front();
        end
      end
      default: ;
    endcase
    rsp.queue_length = LenBits'(held_ids.size());
    return rsp;
  endfunction

  task automatic report_mismatch(input string what, input logic [KeyBits-1:0] exp_val,
                                 input logic [KeyBits-1:0] got_val);
    $display("[%0d] mismatch on %s: expected %0h, got %0h", cycle_count, what, exp_val,
             got_val);
    error_count++;
  endtask

  always @(negedge clk_i) begin
    rsp_if.ready = ($urandom_range(0, 99) >= stall_pct);
  end

  always @(posedge clk_i) begin
    queue_rsp_t exp_rsp;
    if (rst_ni && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
      if (expected_rsps.size() == 0) begin
        report_mismatch("unexpected response status", '0, KeyBits'(rsp_if.status));
      end else begin
        exp_rsp = expected_rsps.pop_front();
        if (rsp_if.status !== exp_rsp.status)
          report_mismatch("status", KeyBits'(exp_rsp.status), KeyBits'(rsp_if.status));
        if (rsp_if.popped_id !== exp_rsp.popped_id)
          report_mismatch("popped_id", KeyBits'(exp_rsp.popped_id),
                          KeyBits'(rsp_if.popped_id));
        if (rsp_if.popped_key !== exp_rsp.popped_key)
          report_mismatch("popped_key", exp_rsp.popped_key, rsp_if.popped_key);
        if (rsp_if.queue_length !== exp_rsp.queue_length)
          report_mismatch("queue_length", KeyBits'(exp_rsp.queue_length),
                          KeyBits'(rsp_if.queue_length));
      end
    end
  end

  // called at a falling edge, returns at a falling edge
  task automatic send_request(input logic [1:0] act, input logic [IdBits-1:0] id,
                              input logic signed [KeyBits-1:0] key);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      req_if.valid = 1'b0;
      @(negedge clk_i);
    end
    req_if.valid    = 1'b1;
    req_if.action   = act;
    req_if.elem_id  = id;
    req_if.sort_key = key;
    do @(posedge clk_i); while (req_if.ready !== 1'b1);
    expected_rsps.push_back(queue_apply(act, id, key));
    @(negedge clk_i);
  endtask

  task automatic wait_for_responses();
    req_if.valid = 1'b0;
    while (expected_rsps.size() != 0) @(negedge clk_i);
  endtask

  task automatic test_empty_queue();
    send_request(ACT_REMOVE, IdBits'($urandom), $urandom);
    send_request(ACT_APPEND, '0, KeyMin);
    send_request(ACT_INSERT, '0, KeyMax);
    send_request(ActUnused, IdBits'($urandom), $urandom);
  endtask

  // equal keys keep arrival order; append ignores the key
  task automatic test_key_ordering();
    send_request(ACT_INSERT, '1, KeyMax);
    send_request(ACT_INSERT, IdBits'(1), KeyMin);
    send_request(ACT_INSERT, IdBits'(2), '0);
    send_request(ACT_INSERT, IdBits'(3), '0);
    send_request(ACT_APPEND, IdBits'(4), KeyMin);
    send_request(ACT_INSERT, IdBits'(2), KeyMax);
    send_request(ACT_APPEND, IdBits'(4), '0);
    send_request(ACT_REMOVE, IdBits'($urandom), $urandom);
  endtask

  // duplicate on the last entry and the check precedence on a full queue
  task automatic test_full_queue();
    for (int unsigned i = 0; held_ids.size() < Depth; i++) begin
      send_request(i[0] ? ACT_INSERT : ACT_APPEND, IdBits'(40 + i), $urandom);
    end
    send_request(ACT_APPEND, '0, $urandom);
    send_request(ACT_INSERT, held_ids[held_ids.size()-1], $urandom);
    send_request(ACT_INSERT, IdBits'(200), KeyMin);
    send_request(ACT_APPEND, IdBits'(201), KeyMax);
  endtask

  // alternates between filling and draining so both ends are reached often
  task automatic test_random_requests(input int unsigned n_items);
    logic [1:0]                act;
    logic [IdBits-1:0]         id;
    logic signed [KeyBits-1:0] key;
    int unsigned               remove_pct;
    int unsigned               pick;
    for (int unsigned n = 0; n < n_items; n++) begin
      remove_pct = ((n / 48) % 2 == 0) ? 30 : 62;
      pick = $urandom_range(0, 99);
      if (pick < 6) id = '0;
      else if (pick < 20 && held_ids.size() != 0)
        id = held_ids[$urandom_range(0, held_ids.size() - 1)];
      else id = IdBits'($urandom_range(1, (1 << IdBits) - 1));
      pick = $urandom_range(0, 99);
      if (pick < 25) key = KeyBits'(int'($urandom_range(0, 6)) - 3);
      else if (pick < 35) key = $urandom_range(0, 1) ? KeyMin : KeyMax;
      else key = $urandom;
      pick = $urandom_range(0, 99);
      if (pick < 3) act = ActUnused;
      else if (pick < 3 + remove_pct) act = ACT_REMOVE;
      else if ($urandom_range(0, 2) == 0) act = ACT_APPEND;
      else act = ACT_INSERT;
      if ($urandom_range(0, 199) == 0) wait_for_responses();
      send_request(act, id, key);
    end
  endtask

  initial begin
    rst_ni          = 1'b0;
    req_if.valid    = 1'b0;
    req_if.action   = ACT_APPEND;
    req_if.elem_id  = '0;
    req_if.sort_key = '0;
    rsp_if.ready    = 1'b0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;

    send_idle_pct = 10;
    stall_pct     = 68;
    test_empty_queue();
    test_key_ordering();
    test_full_queue();
    test_random_requests(580);
    wait_for_responses();

    send_idle_pct = 68;
    stall_pct     = 10;
    test_random_requests(580);
    wait_for_responses();

    send_idle_pct = 0;
    stall_pct     = 0;
    test_random_requests(590);
    wait_for_responses();
    repeat (4) @(negedge clk_i);

    if (error_count == 0) begin
      $display("sorted_ready_queue_top regression: pass");
    end else begin
      $display("sorted_ready_queue_top regression: fail");
    end
    $finish;
  end

endmodule
